// ----- rtl/core/gapb_pkg.sv -----
package gapb_pkg;

	localparam int CHAN_W   = 8;
	localparam int NUM_CHAN = 3;
	localparam int PIX_W    = 24;
	localparam int ALPHA_W  = 8;
	localparam int PROD_W   = 2 * CHAN_W;
	localparam int MODE_W   = 2;
	localparam int IDX_W    = 2;

	localparam logic [MODE_W-1:0] MODE_565 = 2'd0;
	localparam logic [MODE_W-1:0] MODE_24  = 2'd1;
	localparam logic [MODE_W-1:0] MODE_32  = 2'd2;
	localparam logic [MODE_W-1:0] MODE_BAD = 2'd3;

	localparam logic [IDX_W-1:0] REG_DEPTH     = 2'd0;
	localparam logic [IDX_W-1:0] REG_FG        = 2'd1;
	localparam logic [IDX_W-1:0] REG_BG        = 2'd2;
	localparam logic [IDX_W-1:0] REG_USE_FRAME = 2'd3;

	localparam logic [CHAN_W-1:0] MAX5 = 8'h1F;
	localparam logic [CHAN_W-1:0] MAX6 = 8'h3F;
	localparam logic [CHAN_W-1:0] MAX8 = 8'hFF;

	typedef logic [CHAN_W-1:0] chan_t;

	typedef struct packed {
		logic s2;
		logic s3;
	} stage_en_t;

endpackage

// ----- rtl/core/gapb_chan.sv -----
module gapb_chan (
	input  logic                  clk,
	input  gapb_pkg::stage_en_t   en,
	input  gapb_pkg::chan_t       fg,
	input  gapb_pkg::chan_t       bg,
	input  gapb_pkg::chan_t       alpha,
	input  gapb_pkg::chan_t       max,
	output gapb_pkg::chan_t       value
);

	logic [gapb_pkg::PROD_W-1:0] prod_f;
	logic [gapb_pkg::PROD_W-1:0] prod_b;
	logic [gapb_pkg::PROD_W:0]   sum_w;
	logic [gapb_pkg::PROD_W-1:0] sum_s2;
	gapb_pkg::chan_t             max_s2;
	logic [gapb_pkg::PROD_W:0]   adj;
	gapb_pkg::chan_t             quo;
	gapb_pkg::chan_t             value_s3;

	// stage 2: fg*a + bg*(255-a), max 65025
	assign prod_f = gapb_pkg::PROD_W'(fg) * gapb_pkg::PROD_W'(alpha);
	assign prod_b = gapb_pkg::PROD_W'(bg) * gapb_pkg::PROD_W'(gapb_pkg::MAX8 - alpha);
	assign sum_w  = (gapb_pkg::PROD_W+1)'(prod_f) + (gapb_pkg::PROD_W+1)'(prod_b);

	always_ff @(posedge clk) begin
		if (en.s2) begin
			sum_s2 <= sum_w[gapb_pkg::PROD_W-1:0];
			max_s2 <= max;
		end
	end

	// stage 3: x/255 == (x + 1 + (x >> 8)) >> 8 for x up to 65025
	assign adj = (gapb_pkg::PROD_W+1)'(sum_s2) + (gapb_pkg::PROD_W+1)'(1)
		+ (gapb_pkg::PROD_W+1)'(sum_s2[gapb_pkg::PROD_W-1:gapb_pkg::CHAN_W]);
	assign quo = adj[gapb_pkg::PROD_W-1:gapb_pkg::CHAN_W];

	always_ff @(posedge clk) begin
		if (en.s3) begin
			value_s3 <= (quo > max_s2) ? max_s2 : quo;
		end
	end

	assign value = value_s3;

endmodule

// ----- rtl/core/glyph_alpha_pixel_blend_top.sv -----
// channel   handshake            payload
// in        in_valid/in_stall    alpha[7:0], frame_pixel[23:0]
// out       out_valid/out_stall  pixel[23:0], depth_ok
// cfg       wr_en                wr_index[1:0], wr_data[23:0]
//
// Three register stages (split, multiply-add, divide by 255 and pack). One item per cycle
// sustained while out_stall is low; the multiply-add per channel sets the stage depth.
// arst_n clears the valid bits and loads the register reset values.
// out_stall holds the output item; empty stages still fill, so input stalls only when all
// three stages hold items.
module glyph_alpha_pixel_blend_top (
	input  logic                            clk,
	input  logic                            arst_n,
	input  logic                            wr_en,
	input  logic [gapb_pkg::IDX_W-1:0]      wr_index,
	input  logic [gapb_pkg::PIX_W-1:0]      wr_data,
	input  logic                            in_valid,
	output logic                            in_stall,
	input  logic [gapb_pkg::ALPHA_W-1:0]    alpha,
	input  logic [gapb_pkg::PIX_W-1:0]      frame_pixel,
	output logic                            out_valid,
	input  logic                            out_stall,
	output logic [gapb_pkg::PIX_W-1:0]      pixel,
	output logic                            depth_ok
);

	logic [gapb_pkg::MODE_W-1:0] depth_mode_q;
	logic [gapb_pkg::PIX_W-1:0]  fg_color_q;
	logic [gapb_pkg::PIX_W-1:0]  bg_color_q;
	logic                        use_frame_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			depth_mode_q <= gapb_pkg::MODE_32;
			fg_color_q   <= 24'hFFFFFF;
			bg_color_q   <= '0;
			use_frame_q  <= 1'b0;
		end else if (wr_en) begin
			unique case (wr_index)
				gapb_pkg::REG_DEPTH:     depth_mode_q <= wr_data[gapb_pkg::MODE_W-1:0];
				gapb_pkg::REG_FG:        fg_color_q   <= wr_data;
				gapb_pkg::REG_BG:        bg_color_q   <= wr_data;
				gapb_pkg::REG_USE_FRAME: use_frame_q  <= wr_data[0];
				default:                 ;
			endcase
		end
	end

	// flow control
	logic                valid_s1, valid_s2, valid_s3;
	logic                rdy1, rdy2, rdy3;
	gapb_pkg::stage_en_t en;

	assign rdy3     = !valid_s3 || !out_stall;
	assign rdy2     = !valid_s2 || rdy3;
	assign rdy1     = !valid_s1 || rdy2;
	assign in_stall = !rdy1;
	assign en.s2    = rdy2;
	assign en.s3    = rdy3;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
			valid_s2 <= 1'b0;
			valid_s3 <= 1'b0;
		end else begin
			if (rdy1) valid_s1 <= in_valid;
			if (rdy2) valid_s2 <= valid_s1;
			if (rdy3) valid_s3 <= valid_s2;
		end
	end

	// stage 1: channel split, index 0 blue, 1 green, 2 red
	logic [gapb_pkg::PIX_W-1:0] bg_src;
	gapb_pkg::chan_t            fg_ch  [gapb_pkg::NUM_CHAN];
	gapb_pkg::chan_t            bg_ch  [gapb_pkg::NUM_CHAN];
	gapb_pkg::chan_t            max_ch [gapb_pkg::NUM_CHAN];

	assign bg_src = use_frame_q ? frame_pixel : bg_color_q;

	always_comb begin
		if (depth_mode_q == gapb_pkg::MODE_565) begin
			fg_ch[0]  = gapb_pkg::CHAN_W'(fg_color_q[4:0]);
			fg_ch[1]  = gapb_pkg::CHAN_W'(fg_color_q[10:5]);
			fg_ch[2]  = gapb_pkg::CHAN_W'(fg_color_q[15:11]);
			bg_ch[0]  = gapb_pkg::CHAN_W'(bg_src[4:0]);
			bg_ch[1]  = gapb_pkg::CHAN_W'(bg_src[10:5]);
			bg_ch[2]  = gapb_pkg::CHAN_W'(bg_src[15:11]);
			max_ch[0] = gapb_pkg::MAX5;
			max_ch[1] = gapb_pkg::MAX6;
			max_ch[2] = gapb_pkg::MAX5;
		end else begin
			fg_ch[0]  = fg_color_q[7:0];
			fg_ch[1]  = fg_color_q[15:8];
			fg_ch[2]  = fg_color_q[23:16];
			bg_ch[0]  = bg_src[7:0];
			bg_ch[1]  = bg_src[15:8];
			bg_ch[2]  = bg_src[23:16];
			max_ch[0] = gapb_pkg::MAX8;
			max_ch[1] = gapb_pkg::MAX8;
			max_ch[2] = gapb_pkg::MAX8;
		end
	end

	gapb_pkg::chan_t             alpha_s1;
	gapb_pkg::chan_t             fg_s1  [gapb_pkg::NUM_CHAN];
	gapb_pkg::chan_t             bg_s1  [gapb_pkg::NUM_CHAN];
	gapb_pkg::chan_t             max_s1 [gapb_pkg::NUM_CHAN];
	logic [gapb_pkg::MODE_W-1:0] mode_s1, mode_s2, mode_s3;

	always_ff @(posedge clk) begin
		if (rdy1 && in_valid) begin
			alpha_s1 <= alpha;
			fg_s1    <= fg_ch;
			bg_s1    <= bg_ch;
			max_s1   <= max_ch;
			mode_s1  <= depth_mode_q;
		end
		if (en.s2) mode_s2 <= mode_s1;
		if (en.s3) mode_s3 <= mode_s2;
	end

	gapb_pkg::chan_t value [gapb_pkg::NUM_CHAN];

	for (genvar i = 0; i < gapb_pkg::NUM_CHAN; i++) begin : g_chan
		gapb_chan u_chan (
			.clk   (clk),
			.en    (en),
			.fg    (fg_s1[i]),
			.bg    (bg_s1[i]),
			.alpha (alpha_s1),
			.max   (max_s1[i]),
			.value (value[i])
		);
	end

	// pack
	always_comb begin
		unique case (mode_s3)
			gapb_pkg::MODE_565: pixel = {8'd0, value[2][4:0], value[1][5:0], value[0][4:0]};
			gapb_pkg::MODE_24,
			gapb_pkg::MODE_32:  pixel = {value[2], value[1], value[0]};
			default:            pixel = '0;
		endcase
	end

	assign depth_ok  = (mode_s3 != gapb_pkg::MODE_BAD);
	assign out_valid = valid_s3;

endmodule

// ----- rtl/core/gapb_checker.sv -----
module gapb_checker (
	input logic        clk,
	input logic        arst_n,
	input logic        in_valid,
	input logic        in_stall,
	input logic        out_valid,
	input logic        out_stall,
	input logic [23:0] pixel,
	input logic        depth_ok
);

	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_stall |=> out_valid)
		else $error("output item dropped while stalled");

	a_bad_depth_zero: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !depth_ok |-> pixel == 24'd0)
		else $error("unsupported depth with nonzero pixel");

	a_empty_takes: assert property (@(posedge clk) disable iff (!arst_n)
		!out_valid |-> !in_stall)
		else $error("input stalled with empty output");

	a_latency: assert property (@(posedge clk) disable iff (!arst_n)
		(in_valid && !in_stall) ##1 !out_stall ##1 !out_stall |=> out_valid)
		else $error("item did not reach output in three cycles");

endmodule

bind glyph_alpha_pixel_blend_top gapb_checker u_gapb_checker (
	.clk       (clk),
	.arst_n    (arst_n),
	.in_valid  (in_valid),
	.in_stall  (in_stall),
	.out_valid (out_valid),
	.out_stall (out_stall),
	.pixel     (pixel),
	.depth_ok  (depth_ok)
);

// ----- bench/tb_glyph_alpha_pixel_blend_top.sv -----
module tb_glyph_alpha_pixel_blend_top;
	timeunit 1ns;
	timeprecision 1ps;
	import gapb_pkg::*;

	localparam int PHASES      = 12;
	localparam int RAND_ITEMS  = 138;
	localparam int DIR_ITEMS   = 6;
	localparam int CYCLE_LIMIT = 400000;
	localparam int MAX_SHOWN   = 10;

	localparam logic [ALPHA_W-1:0] DIR_ALPHA [DIR_ITEMS] =
		'{8'd0, 8'd255, 8'd1, 8'd254, 8'd128, 8'd127};
	localparam logic [PIX_W-1:0] DIR_FRAME [DIR_ITEMS] =
		'{24'h000000, 24'hFFFFFF, 24'hFFFFFF, 24'h000000, 24'hAAAAAA, 24'h555555};

	typedef struct packed {
		logic [ALPHA_W-1:0] alpha;
		logic [PIX_W-1:0]   frame;
	} glyph_px_t;

	typedef struct packed {
		logic [PIX_W-1:0] pixel;
		logic             depth_ok;
	} blend_px_t;

	logic                clk;
	logic                arst_n;
	logic                wr_en;
	logic [IDX_W-1:0]    wr_index;
	logic [PIX_W-1:0]    wr_data;
	logic                in_valid;
	logic                in_stall;
	logic [ALPHA_W-1:0]  alpha;
	logic [PIX_W-1:0]    frame_pixel;
	logic                out_valid;
	logic                out_stall;
	logic [PIX_W-1:0]    pixel;
	logic                depth_ok;

	glyph_px_t glyph_q[$];
	blend_px_t blend_due[$];
	glyph_px_t next_glyph;
	blend_px_t want;

	logic [MODE_W-1:0] cfg_depth;
	logic [PIX_W-1:0]  cfg_fg;
	logic [PIX_W-1:0]  cfg_bg;
	logic              cfg_use_frame;

	int  send_idle_pct;
	int  stall_pct;
	int  mismatches;
	int  cycles;
	logic in_fire;

	glyph_alpha_pixel_blend_top dut (
		.clk         (clk),
		.arst_n      (arst_n),
		.wr_en       (wr_en),
		.wr_index    (wr_index),
		.wr_data     (wr_data),
		.in_valid    (in_valid),
		.in_stall    (in_stall),
		.alpha       (alpha),
		.frame_pixel (frame_pixel),
		.out_valid   (out_valid),
		.out_stall   (out_stall),
		.pixel       (pixel),
		.depth_ok    (depth_ok)
	);

	initial begin
		clk = 1'b0;
		forever #2 clk = ~clk;
	end

	function automatic chan_t mix_chan(input chan_t fc, input chan_t bc, input chan_t a,
			input chan_t maxv);
		int unsigned fi, bi, ai, v;
		fi = fc;
		bi = bc;
		ai = a;
		v = (fi * ai + bi * (255 - ai)) / 255;
		if (v > maxv)
			v = maxv;
		return chan_t'(v);
	endfunction

	function automatic blend_px_t blend_pixel(input glyph_px_t g);
		blend_px_t res;
		logic [PIX_W-1:0] under;
		chan_t cr, cg, cb;
		res = '0;
		under = cfg_use_frame ? g.frame : cfg_bg;
		case (cfg_depth)
		MODE_565: begin
			cb = mix_chan({3'b0, cfg_fg[4:0]}, {3'b0, under[4:0]}, g.alpha, MAX5);
			cg = mix_chan({2'b0, cfg_fg[10:5]}, {2'b0, under[10:5]}, g.alpha, MAX6);
			cr = mix_chan({3'b0, cfg_fg[15:11]}, {3'b0, under[15:11]}, g.alpha, MAX5);
			res.pixel = {8'h00, cr[4:0], cg[5:0], cb[4:0]};
			res.depth_ok = 1'b1;
		end
		MODE_24, MODE_32: begin
			cb = mix_chan(cfg_fg[7:0], under[7:0], g.alpha, MAX8);
			cg = mix_chan(cfg_fg[15:8], under[15:8], g.alpha, MAX8);
			cr = mix_chan(cfg_fg[23:16], under[23:16], g.alpha, MAX8);
			res.pixel = {cr, cg, cb};
			res.depth_ok = 1'b1;
		end
		default: begin
			res = '0;
		end
		endcase
		return res;
	endfunction

	function automatic logic [PIX_W-1:0] pick_color();
		case ($urandom_range(7))
		0: return '0;
		1: return {PIX_W{1'b1}};
		default: return PIX_W'($urandom);
		endcase
	endfunction

	// driver
	always @(negedge clk) begin
		if (!arst_n) begin
			in_valid <= 1'b0;
		end else if (!in_valid || in_fire) begin
			if (glyph_q.size() != 0 && $urandom_range(99) >= send_idle_pct) begin
				next_glyph = glyph_q.pop_front();
				in_valid <= 1'b1;
				alpha <= next_glyph.alpha;
				frame_pixel <= next_glyph.frame;
			end else begin
				in_valid <= 1'b0;
			end
		end
	end

	always @(negedge clk) begin
		if (!arst_n) begin
			out_stall <= 1'b0;
		end else begin
			out_stall <= ($urandom_range(99) < stall_pct);
		end
	end

	// monitor
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			in_fire <= 1'b0;
			cycles <= 0;
		end else if (cycles >= CYCLE_LIMIT) begin
			$display("tb_glyph_alpha_pixel_blend_top: done, errors");
			$finish;
		end else begin
			cycles <= cycles + 1;
			in_fire <= in_valid && !in_stall;
			if (in_valid && !in_stall)
				blend_due.push_back(blend_pixel(glyph_px_t'({alpha, frame_pixel})));
			if (out_valid && !out_stall) begin
				if (blend_due.size() == 0) begin
					if (mismatches < MAX_SHOWN)
						$display("unexpected item: pixel %06h depth_ok %0b", pixel, depth_ok);
					mismatches++;
				end else begin
					want = blend_due.pop_front();
					if (pixel !== want.pixel || depth_ok !== want.depth_ok) begin
						if (mismatches < MAX_SHOWN)
							$display("mismatch: pixel exp %06h got %06h, depth_ok exp %0b got %0b",
								want.pixel, pixel, want.depth_ok, depth_ok);
						mismatches++;
					end
				end
			end
		end
	end

	task automatic write_reg(input logic [IDX_W-1:0] idx, input logic [PIX_W-1:0] val);
		@(negedge clk);
		wr_en <= 1'b1;
		wr_index <= idx;
		wr_data <= val;
		@(negedge clk);
		wr_en <= 1'b0;
		case (idx)
		REG_DEPTH:     cfg_depth = val[MODE_W-1:0];
		REG_FG:        cfg_fg = val;
		REG_BG:        cfg_bg = val;
		REG_USE_FRAME: cfg_use_frame = val[0];
		default:       ;
		endcase
	endtask

	// checked at the rising edge, where the driver's outputs are settled
	task automatic settle();
		while (glyph_q.size() != 0 || in_valid || blend_due.size() != 0)
			@(posedge clk);
	endtask

	task automatic queue_random(input int n);
		glyph_px_t g;
		for (int i = 0; i < n; i++) begin
			case ($urandom_range(9))
			0: g.alpha = '0;
			1: g.alpha = '1;
			default: g.alpha = ALPHA_W'($urandom);
			endcase
			g.frame = pick_color();
			glyph_q.push_back(g);
		end
	endtask

	initial begin
		logic [MODE_W-1:0] mode;
		logic [PIX_W-1:0]  fg, bg;
		logic              use_frame;
		arst_n = 1'b0;
		wr_en = 1'b0;
		wr_index = '0;
		wr_data = '0;
		in_valid = 1'b0;
		alpha = '0;
		frame_pixel = '0;
		out_stall = 1'b0;
		send_idle_pct = 0;
		stall_pct = 0;
		mismatches = 0;
		cfg_depth = MODE_32;
		cfg_fg = {PIX_W{1'b1}};
		cfg_bg = '0;
		cfg_use_frame = 1'b0;
		repeat (9) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;

		for (int p = 0; p < PHASES; p++) begin
			if (p != 0) begin
				settle();
				repeat (4) @(negedge clk);
				case (p)
				1: begin
					mode = MODE_565;
					fg = {PIX_W{1'b1}};
					bg = '0;
					use_frame = 1'b1;
				end
				2: begin
					mode = MODE_24;
					fg = '0;
					bg = {PIX_W{1'b1}};
					use_frame = 1'b0;
				end
				3: begin
					mode = MODE_BAD;
					fg = pick_color();
					bg = pick_color();
					use_frame = 1'b1;
				end
				default: begin
					mode = MODE_W'($urandom_range(3));
					fg = pick_color();
					bg = pick_color();
					use_frame = 1'($urandom_range(1));
				end
				endcase
				// upper data bits are junk, the block keeps only the register width
				write_reg(REG_DEPTH, (PIX_W'($urandom) & ~PIX_W'(3)) | PIX_W'(mode));
				write_reg(REG_FG, fg);
				write_reg(REG_BG, bg);
				write_reg(REG_USE_FRAME, (PIX_W'($urandom) & ~PIX_W'(1)) | PIX_W'(use_frame));
			end

			case (p % 4)
			0: begin
				send_idle_pct = 0;
				stall_pct = 0;
			end
			1: begin
				send_idle_pct = 69;
				stall_pct = 0;
			end
			2: begin
				send_idle_pct = 0;
				stall_pct = 69;
			end
			default: begin
				send_idle_pct = 25;
				stall_pct = 25;
			end
			endcase

			if (p < 4)
				for (int k = 0; k < DIR_ITEMS; k++)
					glyph_q.push_back('{alpha: DIR_ALPHA[k], frame: DIR_FRAME[k]});

			queue_random(RAND_ITEMS / 2);
			// hold off the sender until the pipe is empty
			settle();
			queue_random(RAND_ITEMS - RAND_ITEMS / 2);
		end

		settle();
		repeat (8) @(negedge clk);
		mismatches += blend_due.size();
		if (mismatches == 0)
			$display("tb_glyph_alpha_pixel_blend_top: done, clean");
		else
			$display("tb_glyph_alpha_pixel_blend_top: done, errors");
		$finish;
	end

endmodule

// ----- glyph_alpha_pixel_blend_top.f -----
rtl/core/gapb_pkg.sv
rtl/core/gapb_chan.sv
rtl/core/glyph_alpha_pixel_blend_top.sv
rtl/core/gapb_checker.sv
bench/tb_glyph_alpha_pixel_blend_top.sv
